// ----- design/xild_pkg.sv -----
// Package for the x86-64 instruction length decoder: constants, types and
// opcode classification functions shared by the lane and merge modules.
package xild_pkg;

	localparam int MAX_LEN = 15;

	localparam logic [1:0] K_NONE  = 2'd0;
	localparam logic [1:0] K_PLAIN = 2'd1;
	localparam logic [1:0] K_MODRM = 2'd2;

	// What one lane finds about its byte: legacy prefix, operand-size prefix or REX.
	typedef struct packed {
		logic       is_prefix;
		logic       is_osz;
		logic       is_rex;
	} byte_class_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] extra;
		logic       is_esc;
	} op_class_t;

	function automatic logic legacy_prefix(input logic [7:0] b);
		return b == 8'h66 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
			b == 8'h2E || b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65 ||
			b == 8'h36;
	endfunction

	// Classifies a one-byte opcode; imm_z is the operand-sized immediate length.
	function automatic op_class_t classify_op(input logic [7:0] op, input logic [7:0] nxt,
			input logic has_rex, input logic rex_w, input logic [3:0] imm_z);
		op_class_t c;
		logic [2:0] ext;
		ext = nxt[5:3];
		c.kind = K_NONE;
		c.extra = 4'd0;
		c.is_esc = 1'b0;
		if (op == 8'h90 || (op >= 8'h50 && op <= 8'h5F) || op == 8'hC3 || op == 8'hCC ||
				op == 8'hC9 || (op >= 8'h91 && op <= 8'h99) || (op >= 8'h9C && op <= 8'h9F) ||
				(op >= 8'hF8 && op <= 8'hFD) || (op >= 8'hA4 && op <= 8'hA7) ||
				(op >= 8'hAA && op <= 8'hAF)) begin
			c.kind = K_PLAIN;
		end else if (op == 8'hC2) begin
			c.kind = K_PLAIN; c.extra = 4'd2;
		end else if ((op >= 8'hB0 && op <= 8'hB7) || op == 8'hA8 || op == 8'hEB ||
				(op >= 8'h70 && op <= 8'h7F) || op == 8'h6A) begin
			c.kind = K_PLAIN; c.extra = 4'd1;
		end else if (op >= 8'hB8 && op <= 8'hBF) begin
			c.kind = K_PLAIN; c.extra = (has_rex && rex_w) ? 4'd8 : imm_z;
		end else if (op == 8'hA9) begin
			c.kind = K_PLAIN; c.extra = imm_z;
		end else if (op == 8'hE8 || op == 8'hE9 || op == 8'h68) begin
			c.kind = K_PLAIN; c.extra = 4'd4;
		end else if (op == 8'hC8) begin
			c.kind = K_PLAIN; c.extra = 4'd3;
		end else if ((op >= 8'h84 && op <= 8'h8F && op != 8'h80) ||
				((op & 8'hC4) == 8'h00 && op[2:0] <= 3'd3) || op == 8'hFE || op == 8'hFF ||
				(op >= 8'hD0 && op <= 8'hD3) || (op == 8'h63 && has_rex)) begin
			c.kind = K_MODRM;
		end else if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC6 ||
				op == 8'hC0 || op == 8'hC1 || op == 8'h6B) begin
			c.kind = K_MODRM; c.extra = 4'd1;
		end else if (op == 8'h81 || op == 8'hC7 || op == 8'h69) begin
			c.kind = K_MODRM; c.extra = imm_z;
		end else if (op == 8'hF6) begin
			c.kind = K_MODRM; c.extra = (ext <= 3'd1) ? 4'd1 : 4'd0;
		end else if (op == 8'hF7) begin
			c.kind = K_MODRM; c.extra = (ext <= 3'd1) ? imm_z : 4'd0;
		end else if (op == 8'h0F) begin
			c.is_esc = 1'b1;
		end
		return c;
	endfunction

	// Classifies the second byte of a 0F-escaped opcode.
	function automatic op_class_t classify_op2(input logic [7:0] op2);
		op_class_t c;
		c.kind = K_NONE;
		c.extra = 4'd0;
		c.is_esc = 1'b0;
		if (op2 >= 8'h80 && op2 <= 8'h8F) begin
			c.kind = K_PLAIN; c.extra = 4'd4;
		end else if ((op2 >= 8'h90 && op2 <= 8'h9F) || (op2 >= 8'h40 && op2 <= 8'h4F) ||
				op2 == 8'hB6 || op2 == 8'hB7 || op2 == 8'hBE || op2 == 8'hBF ||
				op2 == 8'hAF || op2 == 8'hBC || op2 == 8'hBD || op2 == 8'hA3 ||
				op2 == 8'hAB || op2 == 8'hB3 || op2 == 8'hBB || op2 == 8'hA5 ||
				op2 == 8'hAD || op2 == 8'h1F || op2 == 8'h18) begin
			c.kind = K_MODRM;
		end else if (op2 == 8'hBA || op2 == 8'hA4 || op2 == 8'hAC) begin
			c.kind = K_MODRM; c.extra = 4'd1;
		end else if (op2 == 8'h05 || op2 == 8'h07 || op2 == 8'hA2) begin
			c.kind = K_PLAIN;
		end
		return c;
	endfunction

endpackage

// ----- design/xild_lane.sv -----
// One byte lane of the instruction length decoder: classifies its byte as
// prefix or REX. Depends on xild_pkg.
module xild_lane (
	input  logic [7:0]           code_byte,
	output xild_pkg::byte_class_t cls
);
	import xild_pkg::*;

	always_comb begin
		cls.is_prefix = legacy_prefix(code_byte);
		cls.is_osz    = code_byte == 8'h66;
		cls.is_rex    = code_byte[7:4] == 4'h4;
	end
endmodule

// ----- design/xild_merge.sv -----
// Merge stage: finds the prefix run from the lane flags, then sizes the
// opcode, ModRM, SIB, displacement and immediate. Depends on xild_pkg.
module xild_merge #(
	parameter int WINDOW_BYTES = 16
) (
	input  logic [16*8-1:0]            win,
	input  xild_pkg::byte_class_t [15:0] cls,
	output logic [3:0]                 instr_length,
	output logic                       rip_relative,
	output logic [3:0]                 disp_offset,
	output logic [31:0]                rip_displacement,
	output logic [3:0]                 reg_field
);
	import xild_pkg::*;

	// Byte at position p; positions past the window read as zero.
	function automatic logic [7:0] at(input logic [127:0] w, input logic [5:0] p);
		logic [7:0] b;
		b = 8'd0;
		if (p < 6'(WINDOW_BYTES) && p < 6'd16)
			b = w[p[3:0]*8 +: 8];
		return b;
	endfunction

	logic [4:0]  npfx;
	logic        osz;
	logic [5:0]  pos, pos_m, len;
	logic        has_rex;
	logic [7:0]  rex, op, mb, sib;
	logic [3:0]  imm_z;
	op_class_t   c1, c2, cf;
	logic        rip;
	logic [3:0]  roff;
	logic [31:0] disp;
	logic [3:0]  reg_v;
	logic        ok;

	always_comb begin
		// Prefix run: first lane that is not a prefix, capped at the window.
		npfx = 5'(WINDOW_BYTES);
		for (int i = WINDOW_BYTES - 1; i >= 0; i--)
			if (!cls[i].is_prefix)
				npfx = 5'(i);
		osz = 1'b0;
		for (int i = 0; i < WINDOW_BYTES; i++)
			if (5'(i) < npfx && cls[i].is_osz)
				osz = 1'b1;
		pos = {1'b0, npfx};
		has_rex = (npfx < 5'(WINDOW_BYTES)) && cls[npfx[3:0]].is_rex;
		rex = has_rex ? at(win, pos) : 8'd0;
		pos = pos + (has_rex ? 6'd1 : 6'd0);
		op = at(win, pos);
		pos = pos + 6'd1;
		imm_z = osz ? 4'd2 : 4'd4;
		c1 = classify_op(op, at(win, pos), has_rex, rex[3], imm_z);
		c2 = classify_op2(at(win, pos));
		cf = c1.is_esc ? c2 : c1;
		if (c1.is_esc)
			pos = pos + 6'd1;

		mb = at(win, pos);
		pos_m = pos + 6'd1;
		reg_v = {rex[2], mb[5:3]};
		rip = 1'b0;
		roff = 4'd0;
		disp = 32'd0;
		if (mb[7:6] != 2'd3 && mb[2:0] == 3'd4) begin
			sib = at(win, pos_m);
			pos_m = pos_m + 6'd1;
			if (mb[7:6] == 2'd0 && sib[2:0] == 3'd5)
				pos_m = pos_m + 6'd4;
		end else begin
			sib = 8'd0;
		end
		if (mb[7:6] == 2'd0 && mb[2:0] == 3'd5) begin
			rip = 1'b1;
			roff = pos_m[3:0];
			disp = {at(win, pos_m + 6'd3), at(win, pos_m + 6'd2),
				at(win, pos_m + 6'd1), at(win, pos_m)};
			pos_m = pos_m + 6'd4;
		end else if (mb[7:6] == 2'd1) begin
			pos_m = pos_m + 6'd1;
		end else if (mb[7:6] == 2'd2) begin
			pos_m = pos_m + 6'd4;
		end

		len = (cf.kind == K_MODRM) ? pos_m + {2'd0, cf.extra} : pos + {2'd0, cf.extra};
		ok = cf.kind != K_NONE && len <= 6'(MAX_LEN);
		instr_length     = ok ? len[3:0] : 4'd0;
		rip_relative     = ok && cf.kind == K_MODRM && rip;
		disp_offset      = rip_relative ? roff : 4'd0;
		rip_displacement = rip_relative ? disp : 32'd0;
		reg_field        = (ok && cf.kind == K_MODRM) ? reg_v : 4'd0;
	end
endmodule

// ----- design/x86_64_instruction_length_decoder_top.sv -----
// x86-64 instruction length decoder, top level.
// Instantiates sixteen byte lanes and the merge stage; depends on xild_pkg.
//
// Usage: drive bytes_low/bytes_high with a 16-byte code window and pulse
// start. The window is taken at the edge where start is high and busy low.
// In the next cycle done is high for exactly one cycle with instr_length,
// rip_relative, disp_offset, rip_displacement and reg_field; that beat is
// taken at the edge that ends the cycle, and the receiver cannot stall it.
// A window is accepted every cycle, as busy stays low.
// The rate is set by the single register stage behind the lanes and merge.
// Reset clears done; the result registers hold whatever they held.
// Results of windows that are too long or carry an uncovered opcode are all
// zero.
module x86_64_instruction_length_decoder_top #(
	parameter int WINDOW_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] bytes_low,
	input  logic [63:0] bytes_high,
	output logic        done,
	output logic [3:0]  instr_length,
	output logic        rip_relative,
	output logic [3:0]  disp_offset,
	output logic signed [31:0] rip_displacement,
	output logic [3:0]  reg_field
);
	import xild_pkg::*;

	logic [127:0]          win;
	byte_class_t [15:0]    cls;
	logic [3:0]            len_d, off_d, reg_d;
	logic                  rip_d;
	logic [31:0]           disp_d;
	logic                  done_q;
	logic [3:0]            len_q, off_q, reg_q;
	logic                  rip_q;
	logic [31:0]           disp_q;

	assign win  = {bytes_high, bytes_low};
	assign busy = 1'b0;

	for (genvar g = 0; g < 16; g++) begin : g_lane
		xild_lane u_lane (.code_byte(win[g*8 +: 8]), .cls(cls[g]));
	end

	xild_merge #(.WINDOW_BYTES(WINDOW_BYTES)) u_merge (
		.win(win), .cls(cls), .instr_length(len_d), .rip_relative(rip_d),
		.disp_offset(off_d), .rip_displacement(disp_d), .reg_field(reg_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			len_q  <= len_d;
			rip_q  <= rip_d;
			off_q  <= off_d;
			disp_q <= disp_d;
			reg_q  <= reg_d;
		end
	end

	assign done             = done_q;
	assign instr_length     = len_q;
	assign rip_relative     = rip_q;
	assign disp_offset      = off_q;
	assign rip_displacement = disp_q;
	assign reg_field        = reg_q;

	// A result beat follows every accepted window in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done) else $error("missing result beat");
	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy)) else $error("stray result beat");
	a_rip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rip_relative) |-> (disp_offset == 4'd0 && rip_displacement == 32'sd0))
		else $error("displacement without RIP operand");
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && instr_length == 4'd0) |-> (!rip_relative && reg_field == 4'd0))
		else $error("fields set on a rejected instruction");
endmodule
